### rtl/lac_pkg.sv
// Shared constants, codes and pipeline types of the layer alpha compositor.
package lac_pkg;

    localparam int FB_DEPTH    = 65536;
    localparam int ADDR_W      = $clog2(FB_DEPTH);
    localparam int IDX_W       = 16;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 4 * CH_W;
    localparam int GRAY_STEPS  = CH_W;
    localparam int DIV_STEPS   = CH_W;
    localparam int MIX_STAGES  = 4;
    localparam int LANES       = 4;
    localparam int ALPHA_LANE  = 3;
    localparam int CFG_W       = 9;

    localparam logic [15:0] OPAQUE_FX    = 16'd65280;
    localparam logic [8:0]  OPACITY_FULL = 9'd256;
    localparam logic [7:0]  ALPHA_FULL   = 8'd255;

    localparam logic [1:0] KIND_COLOUR = 2'd0;
    localparam logic [1:0] KIND_GRAY   = 2'd1;
    localparam logic [1:0] KIND_ENUM   = 2'd2;

    localparam logic [1:0] CFG_KIND       = 2'd0;
    localparam logic [1:0] CFG_OPACITY    = 2'd1;
    localparam logic [1:0] CFG_ENUM_COUNT = 2'd2;
    localparam logic [1:0] CFG_MASK       = 2'd3;

    localparam logic MODE_CLEAR = 1'b0;

    typedef enum logic [1:0] {
        RES_BLEND = 2'd0,
        RES_KEEP  = 2'd1,
        RES_ZERO  = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             wr;
        res_sel_t         sel;
        logic [PIX_W-1:0] keep;
    } tag_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } track_t;

    // One item of the source pipeline while the enumeration gray is divided out.
    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic [2:0][7:0]  col;
        logic [7:0]       alpha;
        logic             skip;
        logic             use_gray;
        logic             gray_zero;
        logic             gray_sat;
        logic [15:0]      rem;
        logic [8:0]       dvsr;
        logic [7:0]       quo;
    } src_stage_t;

    typedef struct packed {
        logic             valid;
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic [2:0][7:0]  col;
        logic [7:0]       alpha;
        logic             skip;
    } src_item_t;

    typedef struct packed {
        logic            valid;
        tag_t            tag;
        logic [2:0][7:0] cs;
        logic [2:0][7:0] cd;
        logic [7:0]      da;
        logic [15:0]     s;
    } p1_t;

    typedef struct packed {
        logic            valid;
        tag_t            tag;
        logic [2:0][7:0] cs;
        logic [2:0][7:0] cd;
        logic [23:0]     s255;
        logic [23:0]     dat;
    } p2_t;

    typedef struct packed {
        logic                   valid;
        tag_t                   tag;
        logic [23:0]            a;
        logic [LANES-1:0][31:0] rem;
        logic [LANES-1:0][7:0]  quo;
    } div_stage_t;

endpackage

### rtl/lac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/lac_src.sv
// Source pipeline: input register and bit-per-stage division for enumeration gray.
module lac_src (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic                      mode,
    input  logic [lac_pkg::IDX_W-1:0] pixel_index,
    input  logic [7:0]                src_red,
    input  logic [7:0]                src_green,
    input  logic [7:0]                src_blue,
    input  logic [7:0]                src_alpha,
    input  logic [7:0]                data_value,
    input  logic [7:0]                mask_alpha,
    input  logic [1:0]                layer_kind,
    input  logic [8:0]                enum_count,
    input  logic                      mask_present,
    output lac_pkg::src_item_t        src_out
);

    lac_pkg::src_stage_t stg_reg  [lac_pkg::GRAY_STEPS+1];
    lac_pkg::src_stage_t stg_next [lac_pkg::GRAY_STEPS+1];
    logic [15:0]         dvsr_sh  [lac_pkg::GRAY_STEPS+1];
    logic [8:0]          n_eff;
    logic [7:0]          gray;

    always_comb
    begin
        n_eff = (enum_count == 9'd0) ? 9'd1 : enum_count;
        stg_next[0]           = '0;
        stg_next[0].valid     = in_valid;
        stg_next[0].mode      = mode;
        stg_next[0].idx       = pixel_index;
        stg_next[0].rem       = 16'({8'd0, data_value} * 16'd255);
        stg_next[0].dvsr      = n_eff - 9'd1;
        stg_next[0].gray_zero = (n_eff == 9'd1);
        stg_next[0].gray_sat  = ({1'b0, stg_next[0].rem[15:8]} >= stg_next[0].dvsr);
        dvsr_sh[0]            = '0;
        unique case (layer_kind)
            lac_pkg::KIND_COLOUR:
            begin
                stg_next[0].col   = {src_blue, src_green, src_red};
                stg_next[0].alpha = src_alpha;
            end
            lac_pkg::KIND_ENUM:
            begin
                stg_next[0].col      = '0;
                stg_next[0].alpha    = lac_pkg::ALPHA_FULL;
                stg_next[0].use_gray = 1'b1;
                stg_next[0].skip     = mask_present && (mask_alpha == 8'd0);
            end
            default:
            begin
                // Grayscale data layer; the unused kind code behaves the same.
                stg_next[0].col   = {data_value, data_value, data_value};
                stg_next[0].alpha = lac_pkg::ALPHA_FULL;
                stg_next[0].skip  = mask_present && (mask_alpha == 8'd0);
            end
        endcase

        for (int k = 1; k <= lac_pkg::GRAY_STEPS; k++)
        begin
            stg_next[k] = stg_reg[k-1];
            dvsr_sh[k]  = {7'd0, stg_reg[k-1].dvsr} << (lac_pkg::GRAY_STEPS - k);
            if (stg_reg[k-1].rem >= dvsr_sh[k])
            begin
                stg_next[k].rem                         = stg_reg[k-1].rem - dvsr_sh[k];
                stg_next[k].quo[lac_pkg::GRAY_STEPS-k]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= lac_pkg::GRAY_STEPS; k++)
            begin
                stg_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k <= lac_pkg::GRAY_STEPS; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_comb
    begin
        priority if (stg_reg[lac_pkg::GRAY_STEPS].gray_zero)
        begin
            gray = 8'd0;
        end
        else if (stg_reg[lac_pkg::GRAY_STEPS].gray_sat)
        begin
            gray = lac_pkg::ALPHA_FULL;
        end
        else
        begin
            gray = stg_reg[lac_pkg::GRAY_STEPS].quo;
        end
        src_out.valid = stg_reg[lac_pkg::GRAY_STEPS].valid;
        src_out.mode  = stg_reg[lac_pkg::GRAY_STEPS].mode;
        src_out.idx   = stg_reg[lac_pkg::GRAY_STEPS].idx;
        src_out.alpha = stg_reg[lac_pkg::GRAY_STEPS].alpha;
        src_out.skip  = stg_reg[lac_pkg::GRAY_STEPS].skip;
        src_out.col   = stg_reg[lac_pkg::GRAY_STEPS].use_gray ? {gray, gray, gray}
                                                              : stg_reg[lac_pkg::GRAY_STEPS].col;
    end

endmodule

### rtl/lac_mix.sv
// Blend front end: source alpha, result selection, output alpha and the blend numerators.
module lac_mix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  lac_pkg::src_item_t        m_in,
    input  logic [lac_pkg::PIX_W-1:0] ram_rdata,
    input  logic [8:0]                alpha_scale,
    output lac_pkg::div_stage_t       div_in,
    output lac_pkg::track_t           track [lac_pkg::MIX_STAGES]
);

    lac_pkg::src_item_t  m_reg;
    lac_pkg::p1_t        p1_reg;
    lac_pkg::p1_t        p1_next;
    lac_pkg::p2_t        p2_reg;
    lac_pkg::p2_t        p2_next;
    lac_pkg::div_stage_t p3_reg;
    lac_pkg::div_stage_t p3_next;
    logic [8:0]          op_sat;
    logic [16:0]         s_prod;
    logic                in_range;
    logic [15:0]         t_val;
    logic [23:0]         a_val;
    logic [15:0]         a_hi;
    logic [16:0]         a_quo;

    // Source alpha S = alpha * opacity, in units of 1/65280.
    always_comb
    begin
        op_sat   = (alpha_scale > lac_pkg::OPACITY_FULL) ? lac_pkg::OPACITY_FULL
                                                         : alpha_scale;
        s_prod   = 17'(m_reg.alpha) * 17'(op_sat);
        in_range = {16'd0, m_reg.idx} < 32'(lac_pkg::FB_DEPTH);
        p1_next          = '0;
        p1_next.valid    = m_reg.valid;
        p1_next.tag.idx  = m_reg.idx;
        p1_next.tag.keep = ram_rdata;
        p1_next.cs       = m_reg.col;
        p1_next.cd       = {ram_rdata[23:16], ram_rdata[15:8], ram_rdata[7:0]};
        p1_next.da       = ram_rdata[31:24];
        p1_next.s        = s_prod[15:0];
        priority if (!in_range)
        begin
            p1_next.tag.sel = lac_pkg::RES_ZERO;
            p1_next.tag.wr  = 1'b0;
        end
        else if (m_reg.mode == lac_pkg::MODE_CLEAR)
        begin
            p1_next.tag.sel = lac_pkg::RES_ZERO;
            p1_next.tag.wr  = 1'b1;
        end
        else if (m_reg.skip || (s_prod == 17'd0))
        begin
            p1_next.tag.sel = lac_pkg::RES_KEEP;
            p1_next.tag.wr  = 1'b0;
        end
        else
        begin
            p1_next.tag.sel = lac_pkg::RES_BLEND;
            p1_next.tag.wr  = 1'b1;
        end
    end

    always_comb
    begin
        t_val         = lac_pkg::OPAQUE_FX - p1_reg.s;
        p2_next.valid = p1_reg.valid;
        p2_next.tag   = p1_reg.tag;
        p2_next.cs    = p1_reg.cs;
        p2_next.cd    = p1_reg.cd;
        p2_next.s255  = {p1_reg.s, 8'd0} - {8'd0, p1_reg.s};
        p2_next.dat   = 24'(p1_reg.da) * 24'(t_val);
    end

    // Output alpha numerator A, and per channel cs*S*255 + cd*da*(65280 - S).
    // The output alpha A / 65280 is (A / 256) / 255, and x / 255 is
    // (x + x / 256 + 1) / 256 for every x that A / 256 can reach.
    always_comb
    begin
        a_val         = p2_reg.s255 + p2_reg.dat;
        a_hi          = a_val[23:8];
        a_quo         = 17'(a_hi) + 17'(a_hi[15:8]) + 17'd1;
        p3_next.valid = p2_reg.valid;
        p3_next.tag   = p2_reg.tag;
        p3_next.a     = a_val;
        p3_next.quo   = '0;
        for (int l = 0; l < lac_pkg::ALPHA_LANE; l++)
        begin
            p3_next.rem[l] = 32'(p2_reg.cs[l]) * 32'(p2_reg.s255)
                           + 32'(p2_reg.cd[l]) * 32'(p2_reg.dat);
        end
        p3_next.rem[lac_pkg::ALPHA_LANE] = '0;
        p3_next.quo[lac_pkg::ALPHA_LANE] = a_quo[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg  <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else if (adv)
        begin
            m_reg  <= m_in;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
        end
    end

    assign div_in   = p3_reg;
    assign track[0] = '{valid: m_reg.valid,  idx: m_reg.idx};
    assign track[1] = '{valid: p1_reg.valid, idx: p1_reg.tag.idx};
    assign track[2] = '{valid: p2_reg.valid, idx: p2_reg.tag.idx};
    assign track[3] = '{valid: p3_reg.valid, idx: p3_reg.tag.idx};

endmodule

### rtl/lac_div.sv
// Three-lane restoring divider, one quotient bit per stage, for the colour channels.
module lac_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  lac_pkg::div_stage_t div_in,
    output lac_pkg::div_stage_t div_out,
    output lac_pkg::track_t     track [lac_pkg::DIV_STEPS]
);

    lac_pkg::div_stage_t stg_reg  [lac_pkg::DIV_STEPS];
    lac_pkg::div_stage_t stg_next [lac_pkg::DIV_STEPS];
    lac_pkg::div_stage_t prev     [lac_pkg::DIV_STEPS];
    logic [31:0]         dvsr_sh  [lac_pkg::DIV_STEPS][lac_pkg::ALPHA_LANE];

    assign prev[0] = div_in;

    for (genvar k = 1; k < lac_pkg::DIV_STEPS; k++)
    begin : g_link
        assign prev[k] = stg_reg[k-1];
    end

    // Colour lanes divide by A; the alpha quotient arrives ready and passes through.
    always_comb
    begin
        for (int k = 0; k < lac_pkg::DIV_STEPS; k++)
        begin
            stg_next[k] = prev[k];
            for (int l = 0; l < lac_pkg::ALPHA_LANE; l++)
            begin
                dvsr_sh[k][l] = 32'(prev[k].a) << (lac_pkg::DIV_STEPS - 1 - k);
                if (prev[k].rem[l] >= dvsr_sh[k][l])
                begin
                    stg_next[k].rem[l] = prev[k].rem[l] - dvsr_sh[k][l];
                    stg_next[k].quo[l][lac_pkg::DIV_STEPS-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < lac_pkg::DIV_STEPS; k++)
            begin
                stg_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k < lac_pkg::DIV_STEPS; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    for (genvar k = 0; k < lac_pkg::DIV_STEPS; k++)
    begin : g_track
        assign track[k] = '{valid: stg_reg[k].valid, idx: stg_reg[k].tag.idx};
    end

    assign div_out = stg_reg[lac_pkg::DIV_STEPS-1];

endmodule

### rtl/layer_alpha_compositor.sv
// Top level of the layer alpha compositor: frame buffer, interlock and output register.
//
// Usage: one item on the slave stream names a pixel of the frame buffer and either clears
// it or blends a layer pixel over it with non-premultiplied source-over. Layers are sent
// bottom to top. Every accepted item gives exactly one result item on the master stream
// carrying the pixel index, the buffer contents after the step and a written flag. The
// user must write layer settings (cfg port) only while no item is in flight; not enforced.
//
// From acceptance to the result an item passes nine source stages (the enumeration gray
// is divided out one bit per stage), the frame buffer read, three multiply stages, eight
// divider stages and the output register. Throughput is one item per cycle. An item
// whose pixel is still in flight further down the pipeline waits at the buffer read
// port until that earlier item has written back; this read-after-write interlock and
// a stalled receiver are the only things that lower the rate below one item per cycle.
//
// Reset clears the pipeline valid bits and restores the layer settings (colour layer,
// full opacity, one enumeration value, no mask). The frame buffer is not cleared; a pixel
// must be written (cleared or blended) before its contents mean anything. When the
// receiver stalls, the whole pipeline holds and the input stalls with it.
module layer_alpha_compositor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // pixel_index, src_red, src_green, src_blue,
                                       // src_alpha, data_value, mask_alpha
    input  logic [0:0]  s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_index, out_red, out_green, out_blue, out_alpha
    output logic [0:0]  m_axis_tuser,  // was_written
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    logic [1:0]  layer_kind_reg;
    logic [8:0]  alpha_scale_reg;
    logic [8:0]  enum_count_reg;
    logic        mask_present_reg;

    logic        adv;
    logic        front_adv;
    logic        hazard;

    lac_pkg::src_item_t  src_out;
    lac_pkg::src_item_t  m_in;
    lac_pkg::div_stage_t div_in;
    lac_pkg::div_stage_t div_out;
    lac_pkg::track_t     mix_track [lac_pkg::MIX_STAGES];
    lac_pkg::track_t     div_track [lac_pkg::DIV_STEPS];

    logic                      ram_we;
    logic [lac_pkg::ADDR_W-1:0] ram_waddr;
    logic [lac_pkg::PIX_W-1:0]  ram_wdata;
    logic                      ram_re;
    logic [lac_pkg::ADDR_W-1:0] ram_raddr;
    logic [lac_pkg::PIX_W-1:0]  ram_rdata;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [47:0]               out_data_reg;
    logic [47:0]               out_data_next;
    logic                      out_wr_reg;
    logic                      out_wr_next;
    logic [lac_pkg::PIX_W-1:0] final_entry;

    // Layer settings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_kind_reg   <= lac_pkg::KIND_COLOUR;
            alpha_scale_reg  <= lac_pkg::OPACITY_FULL;
            enum_count_reg   <= 9'd1;
            mask_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lac_pkg::CFG_KIND:       layer_kind_reg   <= cfg_data[1:0];
                lac_pkg::CFG_OPACITY:    alpha_scale_reg  <= cfg_data;
                lac_pkg::CFG_ENUM_COUNT: enum_count_reg   <= cfg_data;
                lac_pkg::CFG_MASK:       mask_present_reg <= cfg_data[0];
            endcase
        end
    end

    // All but the source stages move whenever the output register can take a result.
    assign adv = !out_valid_reg || m_axis_tready;

    // Read-after-write interlock: the item about to read the buffer must not share its
    // pixel with any item that has read but not yet written back.
    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < lac_pkg::MIX_STAGES; i++)
        begin
            if (mix_track[i].valid && (mix_track[i].idx == src_out.idx))
            begin
                hazard = 1'b1;
            end
        end
        for (int i = 0; i < lac_pkg::DIV_STEPS; i++)
        begin
            if (div_track[i].valid && (div_track[i].idx == src_out.idx))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign front_adv     = adv && !(src_out.valid && hazard);
    assign s_axis_tready = front_adv;

    always_comb
    begin
        m_in       = src_out;
        m_in.valid = src_out.valid && !hazard;
    end

    assign ram_re    = adv && m_in.valid;
    assign ram_raddr = lac_pkg::ADDR_W'(src_out.idx);

    lac_src u_src (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (front_adv),
        .in_valid     (s_axis_tvalid),
        .mode         (s_axis_tuser[0]),
        .pixel_index  (s_axis_tdata[15:0]),
        .src_red      (s_axis_tdata[23:16]),
        .src_green    (s_axis_tdata[31:24]),
        .src_blue     (s_axis_tdata[39:32]),
        .src_alpha    (s_axis_tdata[47:40]),
        .data_value   (s_axis_tdata[55:48]),
        .mask_alpha   (s_axis_tdata[63:56]),
        .layer_kind   (layer_kind_reg),
        .enum_count   (enum_count_reg),
        .mask_present (mask_present_reg),
        .src_out      (src_out)
    );

    lac_ram #(
        .WIDTH (lac_pkg::PIX_W),
        .DEPTH (lac_pkg::FB_DEPTH)
    ) u_frame_buffer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lac_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .m_in        (m_in),
        .ram_rdata   (ram_rdata),
        .alpha_scale (alpha_scale_reg),
        .div_in      (div_in),
        .track       (mix_track)
    );

    lac_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .div_in  (div_in),
        .div_out (div_out),
        .track   (div_track)
    );

    // Write back and build the result. A buffer entry is packed red in the low byte,
    // then green, blue and alpha.
    always_comb
    begin
        unique case (div_out.tag.sel)
            lac_pkg::RES_BLEND:
            begin
                final_entry = {div_out.quo[3], div_out.quo[2], div_out.quo[1], div_out.quo[0]};
            end
            lac_pkg::RES_KEEP:
            begin
                final_entry = div_out.tag.keep;
            end
            default:
            begin
                final_entry = '0;
            end
        endcase
        ram_we         = adv && div_out.valid && div_out.tag.wr;
        ram_waddr      = lac_pkg::ADDR_W'(div_out.tag.idx);
        ram_wdata      = final_entry;
        out_valid_next = adv ? div_out.valid : out_valid_reg;
        out_data_next  = {final_entry, div_out.tag.idx};
        out_wr_next    = div_out.tag.wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_wr_reg   <= out_wr_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_wr_reg;

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("frame buffer read and write hit the same pixel in one cycle");

    a_hazard_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (src_out.valid && hazard) |-> !s_axis_tready)
        else $error("input accepted while the buffer read port is interlocked");

    a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (adv && out_valid_next))
        else $error("frame buffer written without a result entering the output");

    a_write_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (m_axis_tvalid && m_axis_tuser[0]))
        else $error("written pixel reported as not written");
`endif

endmodule

### tb/tb_layer_alpha_compositor.sv
// Testbench of the layer alpha compositor: random and directed pixels checked against a predictor.

class blend_scoreboard;
    logic [31:0] pixel_store [int];
    logic [1:0]  kind;
    logic [8:0]  opacity;
    logic [8:0]  enum_cnt;
    logic        mask_on;
    logic [47:0] want_data [$];
    logic        want_wr [$];
    int          errors;

    function new();
        kind = lac_pkg::KIND_COLOUR;
        opacity = 9'd256;
        enum_cnt = 9'd1;
        mask_on = 1'b0;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] val);
        case (idx)
            lac_pkg::CFG_KIND:       kind = val[1:0];
            lac_pkg::CFG_OPACITY:    opacity = val;
            lac_pkg::CFG_ENUM_COUNT: enum_cnt = val;
            lac_pkg::CFG_MASK:       mask_on = val[0];
            default: ;
        endcase
    endfunction

    function logic [7:0] mix(logic [7:0] cs, logic [7:0] cd, longint s, longint da, longint a);
        longint num;
        longint q;
        num = longint'(cs) * s * 255 + longint'(cd) * da * (65280 - s);
        q = num / a;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Works out the buffer entry after one item and queues the expected result.
    function void note_item(logic mode, logic [15:0] idx, logic [7:0] sr, logic [7:0] sg,
                            logic [7:0] sb, logic [7:0] sa, logic [7:0] dv, logic [7:0] ma);
        logic [31:0] entry;
        logic        wr;
        logic        skip;
        longint      op;
        longint      s;
        longint      n;
        longint      g;
        longint      a;
        longint      oa;
        entry = pixel_store.exists(idx) ? pixel_store[idx] : 32'd0;
        wr = 1'b0;
        skip = 1'b0;
        if (mode == lac_pkg::MODE_CLEAR) begin
            entry = 32'd0;
            wr = 1'b1;
        end
        else begin
            op = (opacity > 256) ? 256 : opacity;
            if (kind != lac_pkg::KIND_COLOUR) begin
                if (mask_on && ma == 0) skip = 1'b1;
                if (kind == lac_pkg::KIND_ENUM) begin
                    n = (enum_cnt == 0) ? 1 : enum_cnt;
                    g = 0;
                    if (n > 1) begin
                        g = (longint'(dv) * 255) / (n - 1);
                        if (g > 255) g = 255;
                    end
                    sr = g[7:0]; sg = g[7:0]; sb = g[7:0];
                end
                else begin
                    sr = dv; sg = dv; sb = dv;
                end
                sa = 8'd255;
            end
            s = longint'(sa) * op;
            if (!skip && s != 0) begin
                a = s * 255 + longint'(entry[31:24]) * (65280 - s);
                oa = a / 65280;
                if (oa > 255) oa = 255;
                entry = {oa[7:0],
                         mix(sb, entry[23:16], s, entry[31:24], a),
                         mix(sg, entry[15:8], s, entry[31:24], a),
                         mix(sr, entry[7:0], s, entry[31:24], a)};
                wr = 1'b1;
            end
        end
        pixel_store[idx] = entry;
        want_data.push_back({entry, idx});
        want_wr.push_back(wr);
    endfunction

    function void check_result(logic [47:0] data, logic wr);
        logic [47:0] ed;
        logic        ew;
        if (want_data.size() == 0) begin
            $display("%0t: unexpected result %h wr %b", $time, data, wr);
            errors++;
            return;
        end
        ed = want_data.pop_front();
        ew = want_wr.pop_front();
        if (ed !== data) begin
            $display("%0t: pixel mismatch expected %h actual %h", $time, ed, data);
            errors++;
        end
        if (ew !== wr) begin
            $display("%0t: written flag mismatch expected %b actual %b", $time, ew, wr);
            errors++;
        end
    endfunction
endclass

module tb_layer_alpha_compositor;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    blend_scoreboard board;
    // Pixels already written; only these may be read by a blend or a skip.
    bit          touched [int];
    int          cycle_count;
    bit          long_hold;

    layer_alpha_compositor u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check every accepted result and give up at a cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
        if (cycle_count > 5000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, mostly short, sometimes long, plus one very long hold.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            if ($urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 1) ? 1 : $urandom_range(5, 30)) @(posedge clk);
        end
    end

    task automatic send_item(logic mode, logic [15:0] idx, logic [7:0] sr, logic [7:0] sg,
                             logic [7:0] sb, logic [7:0] sa, logic [7:0] dv, logic [7:0] ma);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {8'd0, ma, dv, sa, sb, sg, sr, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_item(mode, idx, sr, sg, sb, sa, dv, ma);
        touched[idx] = 1;
    endtask

    // Sometimes lowers valid for a random gap.
    task automatic sender_gap();
        int gap;
        if ($urandom_range(0, 4) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every expected result has come, then lets the pipeline drain.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.want_data.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Picks a pixel; a small pool gives plenty of back-to-back hazards.
    function automatic logic [15:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom_range(0, 31));
        if (r < 8) return 16'($urandom_range(65504, 65535));
        return 16'($urandom);
    endfunction

    task automatic random_item();
        logic [15:0] idx;
        logic        mode;
        idx = pick_pixel();
        mode = touched.exists(idx) ? ($urandom_range(0, 7) != 0) : lac_pkg::MODE_CLEAR;
        send_item(mode, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom),
                  8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
        sender_gap();
    endtask

    initial
    begin
        // Settings per phase: kind, opacity, enum count, mask.
        logic [8:0] settings [12][4];
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        long_hold = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings: clear, opaque, transparent and translucent colour pixels.
        send_item(lac_pkg::MODE_CLEAR, 16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(lac_pkg::MODE_CLEAR, 16'd65535, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(1'b1, 16'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0);
        send_item(1'b1, 16'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0);
        send_item(1'b1, 16'd65535, 8'd0, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255);
        send_item(1'b1, 16'd0, 8'd10, 8'd20, 8'd30, 8'd128, 8'd0, 8'd0);
        wait_drained();
        // Zero opacity leaves pixels alone; over 256 saturates.
        write_reg(lac_pkg::CFG_OPACITY, 9'd0);
        send_item(1'b1, 16'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'd0);
        wait_drained();
        write_reg(lac_pkg::CFG_OPACITY, 9'd511);
        send_item(1'b1, 16'd0, 8'd9, 8'd8, 8'd7, 8'd100, 8'd0, 8'd0);
        wait_drained();
        // Grayscale layer with a mask: masked and unmasked pixels.
        write_reg(lac_pkg::CFG_KIND, {7'd0, lac_pkg::KIND_GRAY});
        write_reg(lac_pkg::CFG_MASK, 9'd1);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 8'd0);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200, 8'd255);
        wait_drained();
        // Enumeration: one value gives black, zero count too, two values saturate, 511 a mid gray.
        write_reg(lac_pkg::CFG_KIND, {7'd0, lac_pkg::KIND_ENUM});
        write_reg(lac_pkg::CFG_OPACITY, 9'd128);
        send_item(1'b1, 16'd65535, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd1);
        wait_drained();
        write_reg(lac_pkg::CFG_ENUM_COUNT, 9'd0);
        send_item(1'b1, 16'd65535, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7, 8'd1);
        wait_drained();
        write_reg(lac_pkg::CFG_ENUM_COUNT, 9'd2);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 8'd9);
        wait_drained();
        write_reg(lac_pkg::CFG_ENUM_COUNT, 9'd511);
        send_item(1'b1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd9);
        wait_drained();
        // Kind three behaves as grayscale.
        write_reg(lac_pkg::CFG_KIND, 9'd3);
        send_item(1'b1, 16'd65535, 8'd0, 8'd0, 8'd0, 8'd0, 8'd77, 8'd0);
        wait_drained();

        settings = '{'{0, 256, 1, 0}, '{0, 0, 1, 0}, '{0, 1, 1, 1}, '{0, 300, 5, 0},
                     '{1, 256, 1, 1}, '{1, 37, 1, 0}, '{2, 256, 256, 1}, '{2, 200, 3, 1},
                     '{2, 511, 1, 0}, '{3, 129, 0, 1}, '{2, 64, 17, 0}, '{0, 255, 9, 1}};
        for (int ph = 0; ph < 12; ph++) begin
            for (int r = 0; r < 4; r++)
                write_reg(r[1:0], settings[ph][r]);
            // In one phase the receiver holds off while items keep coming.
            if (ph == 3) long_hold = 1'b1;
            for (int k = 0; k < 160; k++)
                random_item();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.want_data.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
